// ----- rtl/bld_pkg.sv -----
// Package for the debounced button LED dimmer.
// Holds command codes, register indexes and fixed-point scaling constants.
// No dependencies.
package bld_pkg;

  // Command codes carried in the input tuser field
  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_OFF  = 3'd1,
    CMD_ON   = 3'd2,
    CMD_SET  = 3'd3,
    CMD_GET  = 3'd4
  } cmd_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_HOLD     = 3'd1,
    CFG_MIN      = 3'd2,
    CFG_MAX      = 3'd3,
    CFG_STEP     = 3'd4
  } cfg_idx_t;

  localparam int CFG_DATA_W = 16;

  // Percent scaling: x / 100 == (x * 5243) >> 19 for every x below 43690,
  // and pct * max_level is at most 127 * 255 = 32385.
  localparam int PCT_SCALE   = 100;
  localparam int RECIP       = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PCT_W       = 7;
  localparam int SCALE_W     = 21;                 // holds 255 * RECIP
  localparam int PROD_W      = PCT_W + SCALE_W;    // pct * scale
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam int TICK_W = 16;

endpackage

// ----- rtl/debounced_button_led_dimmer.sv -----
// Top level of the debounced button LED dimmer.
// Debounce, press timing, ramp, toggle and command handling in one pass.
// Depends on bld_pkg.
//
//  port group | dir | beat content (low bit first)
//  -----------+-----+-----------------------------------------------------
//  in_*       | in  | tdata: button_level[0], dim_percent[7:1]; tuser: cmd
//  out_*      | out | tdata: pwm_level[7:0], pressed[8], set_report[9],
//             |     |        get_report[10], zeros[15:11]
//  cfg_*      | in  | cfg_index selects the register, cfg_data is written
//
// One beat per clock cycle sustained while the result side is ready; each tick
// passes through an input register and then a result register, where its
// result is presented and held until taken.
// The tick's state update is one pass of adds,
// compares and a single 7 x 21 multiply for percent scaling.
// Synchronous active-low reset clears valid flags and tick state and loads
// register defaults; there is no clearing pass. A stalled result holds in the
// result register while the input register takes one more beat.
module debounced_button_led_dimmer #(
  parameter int FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // button_level, dim_percent
  input  logic [2:0]                    in_tuser,   // cmd
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,  // pwm_level, pressed,
                                                    // set_report, get_report
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bld_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bld_pkg::*;

  localparam int LW  = 8 + FRAC_BITS;                  // level width
  localparam int LVW = ((LW > TICK_W) ? LW : TICK_W) + 2; // signed ramp sum

  // ---------------------------------------------------------------- config
  logic [TICK_W-1:0]  debounce_ticks_r;
  logic [TICK_W-1:0]  hold_ticks_r;
  logic [7:0]         min_level_r;
  logic [7:0]         max_level_r;
  logic [TICK_W-1:0]  ramp_step_r;
  logic [SCALE_W-1:0] pct_scale_r;   // max_level * RECIP, folded at write

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= TICK_W'(50);
      hold_ticks_r     <= TICK_W'(500);
      min_level_r      <= 8'd0;
      max_level_r      <= 8'd255;
      ramp_step_r      <= TICK_W'(128);
      pct_scale_r      <= SCALE_W'(255 * RECIP);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: debounce_ticks_r <= cfg_data[TICK_W-1:0];
        CFG_HOLD:     hold_ticks_r     <= cfg_data[TICK_W-1:0];
        CFG_MIN:      min_level_r      <= cfg_data[7:0];
        CFG_MAX: begin
          max_level_r <= cfg_data[7:0];
          pct_scale_r <= SCALE_W'({13'd0, cfg_data[7:0]} * SCALE_W'(RECIP));
        end
        CFG_STEP:     ramp_step_r      <= cfg_data[TICK_W-1:0];
        default: ;    // writes beyond the register list are dropped
      endcase
    end
  end

  // ------------------------------------------------------- input register
  logic             a_valid_r;
  logic             a_raw_r;
  logic [2:0]       a_cmd_r;
  logic [PCT_W-1:0] a_pct_r;
  logic             adv;         // input register moves into result register

  logic             out_valid_r;
  assign adv       = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_raw_r <= in_tdata[0];
      a_pct_r <= in_tdata[7:1];
      a_cmd_r <= in_tuser;
    end
  end

  // ----------------------------------------------------------- tick state
  logic              raw_prev_r,     raw_prev_nxt;
  logic              stable_level_r, stable_level_nxt;
  logic [TICK_W-1:0] stable_ticks_r, stable_ticks_nxt;
  logic [TICK_W-1:0] hold_count_r,   hold_count_nxt;
  logic              ramping_r,      ramping_nxt;
  logic              ramp_down_r,    ramp_down_nxt;
  logic [LW-1:0]     level_q_r,      level_q_nxt;
  logic [LW-1:0]     saved_level_q_r, saved_level_q_nxt;
  logic              set_rep, get_rep;

  // percent scaling: pct * max_level / 100, clamped to max_level
  logic [PROD_W-1:0] pct_prod;
  logic [QUOT_W-1:0] pct_quot;
  logic [7:0]        pct_level;

  assign pct_prod = {{SCALE_W{1'b0}}, a_pct_r} * {{PCT_W{1'b0}}, pct_scale_r};
  assign pct_quot = pct_prod[PROD_W-1:RECIP_SHIFT];
  assign pct_level = (pct_quot > QUOT_W'(max_level_r)) ? max_level_r
                                                       : pct_quot[7:0];

  logic [LW-1:0]         level_cmd;
  logic [LW-1:0]         level_ramp;
  logic [TICK_W-1:0]     st_inc;
  logic                  rise, fall;
  logic signed [LVW-1:0] lv_base, lv_step, lv_sum, lv_min, lv_max, lv_clamp;
  logic                  lv_down;

  always_comb begin
    get_rep   = 1'b0;
    set_rep   = 1'b0;
    level_cmd = level_q_r;

    // apply the command first
    unique case (cmd_t'(a_cmd_r))
      CMD_OFF:  level_cmd = '0;
      CMD_ON:   level_cmd = {max_level_r, {FRAC_BITS{1'b0}}};
      CMD_SET:  level_cmd = {pct_level, {FRAC_BITS{1'b0}}};
      CMD_GET:  get_rep   = 1'b1;
      default: ;   // none, and unused codes
    endcase

    // debounce the raw level
    rise             = 1'b0;
    fall             = 1'b0;
    stable_level_nxt = stable_level_r;
    st_inc = (stable_ticks_r == '1) ? stable_ticks_r : stable_ticks_r + 1'b1;
    if (a_raw_r != raw_prev_r) begin
      stable_ticks_nxt = '0;
    end else begin
      stable_ticks_nxt = st_inc;
      if (st_inc > debounce_ticks_r) begin
        rise             = a_raw_r && !stable_level_r;
        fall             = !a_raw_r && stable_level_r;
        stable_level_nxt = a_raw_r;
      end
    end
    raw_prev_nxt = a_raw_r;

    // press timing
    if (rise) begin
      hold_count_nxt = '0;
    end else begin
      hold_count_nxt = (hold_count_r == '1) ? hold_count_r : hold_count_r + 1'b1;
    end

    // ramp: min clamp first, then max clamp
    lv_base = $signed(LVW'(level_cmd));
    lv_step = $signed(LVW'(ramp_step_r));
    lv_min  = $signed(LVW'({min_level_r, {FRAC_BITS{1'b0}}}));
    lv_max  = $signed(LVW'({max_level_r, {FRAC_BITS{1'b0}}}));
    lv_sum  = ramp_down_r ? (lv_base - lv_step) : (lv_base + lv_step);
    lv_clamp = lv_sum;
    lv_down  = ramp_down_r;
    if (lv_clamp <= lv_min) begin
      lv_clamp = lv_min;
      lv_down  = 1'b0;
    end
    if (lv_clamp >= lv_max) begin
      lv_clamp = lv_max;
      lv_down  = 1'b1;
    end

    ramping_nxt   = ramping_r;
    ramp_down_nxt = ramp_down_r;
    level_ramp    = level_cmd;
    if (stable_level_nxt && (hold_count_nxt > hold_ticks_r)) begin
      if (!ramping_r) begin
        ramping_nxt = 1'b1;            // first hold tick: enter ramp only
      end else if (ramp_step_r != '0) begin
        level_ramp    = lv_clamp[LW-1:0];
        ramp_down_nxt = lv_down;
        set_rep       = 1'b1;
      end
    end

    // release: a short press toggles between off and the saved level
    level_q_nxt       = level_ramp;
    saved_level_q_nxt = saved_level_q_r;
    if (fall) begin
      ramping_nxt = 1'b0;
      if (hold_count_nxt < hold_ticks_r) begin
        if (level_ramp != '0) begin
          saved_level_q_nxt = level_ramp;
          level_q_nxt       = '0;
        end else begin
          level_q_nxt = saved_level_q_r;
        end
        set_rep = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r      <= 1'b0;
      stable_level_r  <= 1'b0;
      stable_ticks_r  <= '0;
      hold_count_r    <= '0;
      ramping_r       <= 1'b0;
      ramp_down_r     <= 1'b0;
      level_q_r       <= '0;
      saved_level_q_r <= '0;
    end else if (adv) begin
      raw_prev_r      <= raw_prev_nxt;
      stable_level_r  <= stable_level_nxt;
      stable_ticks_r  <= stable_ticks_nxt;
      hold_count_r    <= hold_count_nxt;
      ramping_r       <= ramping_nxt;
      ramp_down_r     <= ramp_down_nxt;
      level_q_r       <= level_q_nxt;
      saved_level_q_r <= saved_level_q_nxt;
    end
  end

  // ------------------------------------------------------ result register
  logic [7:0] out_pwm_r;
  logic       out_pressed_r;
  logic       out_set_r;
  logic       out_get_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pwm_r     <= level_q_nxt[LW-1:FRAC_BITS];
      out_pressed_r <= stable_level_nxt;
      out_set_r     <= set_rep;
      out_get_r     <= get_rep;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_get_r, out_set_r, out_pressed_r, out_pwm_r};

  // ----------------------------------------------------------- assertions
  // a full input register never leaves while the result is stalled
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !adv) |=> a_valid_r)
    else $error("input register dropped a beat");

  // no new beat while both stages are full and the result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("beat accepted with both stages full");

  // pressed flag matches the debounced state it was taken from
  a_pressed_track: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_pressed_r == stable_level_r))
    else $error("pressed flag out of step with debounce state");

  // get_report follows the report command of the same tick
  a_get_report: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_get_r == ($past(a_cmd_r) == CMD_GET)))
    else $error("get_report does not match command");

endmodule

// ----- dv/tb_debounced_button_led_dimmer.sv -----
// Self-checking testbench for the debounced button LED dimmer: a directed table, then random
// press/release episodes under several register settings and handshake idling patterns.
// Depends on bld_pkg and rtl/debounced_button_led_dimmer.sv.
`timescale 1ns / 1ps

module tb_debounced_button_led_dimmer;
  import bld_pkg::*;

  localparam int FRAC_BITS       = 8;
  localparam int LVL_W           = 8 + FRAC_BITS;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int NUM_PHASES      = 12;
  localparam int TICKS_PER_PHASE = 150;
  localparam int PRESSURE_PHASE  = 5;   // receiver holds off at the start of this phase
  localparam int PAUSE_PHASE     = 6;   // sender waits for a full drain halfway through
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;

  // Command codes the block must ignore
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // Idling patterns, percent of cycles: none, sender only, receiver only, both
  localparam int SEND_IDLE_PCT [4] = '{0, 50, 0, 10};
  localparam int RECV_STALL_PCT[4] = '{0, 0, 50, 10};

  // One result beat, as the block should report it
  typedef struct packed {
    logic [7:0] pwm;
    logic       pressed;
    logic       set_rep;
    logic       get_rep;
  } dim_result_t;

  // One input tick
  typedef struct packed {
    logic       btn;
    logic [2:0] cmd;
    logic [6:0] pct;
  } tick_t;

  // Directed row: a register write, or a tick with an optional typed-in result
  typedef struct packed {
    logic        is_cfg;
    cfg_idx_t    idx;
    logic [15:0] val;
    tick_t       tick;
    logic        typed;
    dim_result_t want;
  } dir_row_t;

  function automatic dir_row_t cfg_row(cfg_idx_t idx, logic [15:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic dir_row_t tick_row(logic btn);
    dir_row_t r;
    r = '0;
    r.tick.btn = btn;
    r.tick.cmd = CMD_NONE;
    return r;
  endfunction

  // Command tick with the button released; result follows directly from the command
  function automatic dir_row_t known_row(logic [2:0] cmd, logic [6:0] pct, logic [7:0] pwm,
                                         logic get_rep);
    dir_row_t r;
    r = '0;
    r.tick.cmd = cmd;
    r.tick.pct = pct;
    r.typed = 1'b1;
    r.want.pwm = pwm;
    r.want.get_rep = get_rep;
    return r;
  endfunction

  localparam int NUM_ROWS = 35;
  localparam dir_row_t DIRECTED[NUM_ROWS] = '{
    // Commands at reset defaults (max level 255)
    known_row(CMD_OFF,      7'd0,   8'd0,   1'b0),
    known_row(CMD_ON,       7'd0,   8'd255, 1'b0),
    known_row(CMD_SET,      7'd0,   8'd0,   1'b0),
    known_row(CMD_SET,      7'd50,  8'd127, 1'b0),
    known_row(CMD_SPARE_LO, 7'd0,   8'd127, 1'b0),
    known_row(CMD_SET,      7'd127, 8'd255, 1'b0),   // percent above scale gives full on
    known_row(CMD_GET,      7'd0,   8'd255, 1'b1),
    known_row(CMD_SPARE_HI, 7'd127, 8'd255, 1'b0),
    // Fast debounce, short hold, ramp step of zero
    cfg_row(CFG_DEBOUNCE, 16'd0),
    cfg_row(CFG_HOLD,     16'd2),
    cfg_row(CFG_MIN,      16'd0),
    cfg_row(CFG_MAX,      16'd255),
    cfg_row(CFG_STEP,     16'd0),
    // Release with the press count exactly at hold: no toggle, no ramp
    tick_row(1'b1), tick_row(1'b1), tick_row(1'b0), tick_row(1'b0),
    // Long press: first ramp tick only enters ramping, then a zero step changes nothing
    tick_row(1'b1), tick_row(1'b1), tick_row(1'b1),
    tick_row(1'b1), tick_row(1'b1), tick_row(1'b1),
    // Minimum above maximum while still held: clamp ends at the maximum, heading down
    cfg_row(CFG_MIN,  16'd200),
    cfg_row(CFG_MAX,  16'd100),
    cfg_row(CFG_STEP, 16'h4000),
    cfg_row(CFG_HOLD, 16'd3),
    tick_row(1'b1), tick_row(1'b1),
    tick_row(1'b0), tick_row(1'b0),
    // Short tap: save the level and switch off
    tick_row(1'b1), tick_row(1'b1), tick_row(1'b0), tick_row(1'b0)
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // button_level[0], dim_percent[7:1]
  logic [2:0]  in_tuser = '0;   // cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // pwm_level[7:0], pressed[8], set_report[9], get_report[10]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  debounced_button_led_dimmer #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies, loaded with the reset defaults
  logic [15:0] cur_debounce = 16'd50;
  logic [15:0] cur_hold     = 16'd500;
  logic [7:0]  cur_min      = 8'd0;
  logic [7:0]  cur_max      = 8'd255;
  logic [15:0] cur_step     = 16'd128;

  // Dimmer state, all cleared by reset
  logic             raw_prev   = 1'b0;
  logic             stable_lvl = 1'b0;
  logic [15:0]      stable_cnt = '0;
  logic [15:0]      hold_cnt   = '0;
  logic             ramping    = 1'b0;
  logic             ramp_dn    = 1'b0;
  logic [LVL_W-1:0] level_q    = '0;
  logic [LVL_W-1:0] saved_q    = '0;

  dim_result_t pending_results[$];
  dim_result_t next_result;
  tick_t       tick_plan[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;
  int cycle_count    = 0;
  int mismatch_count = 0;
  int beats_sent     = 0;
  int results_seen   = 0;
  int button_changes = 0;
  int level_reports  = 0;
  int reg_writes     = 0;

  // Advance the dimmer by one tick and return the result it reports
  function automatic dim_result_t dimmer_tick(logic btn, logic [2:0] cmd, logic [6:0] pct);
    dim_result_t r;
    int   scaled;
    int   lv;
    int   lo_q;
    int   hi_q;
    logic rise;
    logic fall;
    r    = '0;
    rise = 1'b0;
    fall = 1'b0;
    lo_q = int'(cur_min) << FRAC_BITS;
    hi_q = int'(cur_max) << FRAC_BITS;

    // Commands act before the button logic
    case (cmd)
      CMD_OFF: level_q = '0;
      CMD_ON:  level_q = LVL_W'(hi_q);
      CMD_SET: begin
        scaled = int'(pct) * int'(cur_max) / PCT_SCALE;
        if (scaled > int'(cur_max)) scaled = int'(cur_max);
        level_q = LVL_W'(scaled << FRAC_BITS);
      end
      CMD_GET: r.get_rep = 1'b1;
      default: ;
    endcase

    // Accept the raw level once it has stayed put long enough
    if (btn != raw_prev) begin
      stable_cnt = '0;
    end else begin
      if (stable_cnt != 16'hFFFF) stable_cnt++;
      if (stable_cnt > cur_debounce) begin
        if (btn != stable_lvl) begin
          rise = btn;
          fall = !btn;
        end
        stable_lvl = btn;
      end
    end
    raw_prev = btn;

    if (rise) hold_cnt = '0;
    else if (hold_cnt != 16'hFFFF) hold_cnt++;

    // Long hold ramps; the minimum clamp is tested before the maximum
    if (stable_lvl && hold_cnt > cur_hold) begin
      if (!ramping) begin
        ramping = 1'b1;
      end else if (cur_step != '0) begin
        lv = int'(level_q);
        lv = ramp_dn ? lv - int'(cur_step) : lv + int'(cur_step);
        r.set_rep = 1'b1;
        if (lv <= lo_q) begin
          lv = lo_q;
          ramp_dn = 1'b0;
        end
        if (lv >= hi_q) begin
          lv = hi_q;
          ramp_dn = 1'b1;
        end
        level_q = LVL_W'(lv);
      end
    end

    // Short press toggles between off and the saved level
    if (fall) begin
      ramping = 1'b0;
      if (hold_cnt < cur_hold) begin
        if (level_q != '0) begin
          saved_q = level_q;
          level_q = '0;
        end else begin
          level_q = saved_q;
        end
        r.set_rep = 1'b1;
      end
    end

    r.pwm     = level_q[FRAC_BITS +: 8];
    r.pressed = stable_lvl;
    return r;
  endfunction

  // Queue one random-content tick with the given button level
  function automatic void plan_tick(logic btn);
    tick_t t;
    t.btn = btn;
    t.cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(1, 7)) : CMD_NONE;
    t.pct = 7'($urandom_range(0, 127));
    tick_plan.push_back(t);
  endfunction

  // Offer one input beat; predict its result once accepted. Keep tvalid high on return.
  task automatic send_tick(input tick_t t, input logic typed, input dim_result_t typed_res);
    dim_result_t res;
    if (cfg_valid) cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t.pct, t.btn};
    in_tuser  <= t.cmd;
    do @(posedge clk); while (!in_tready);
    res = dimmer_tick(t.btn, t.cmd, t.pct);
    pending_results.push_back(typed ? typed_res : res);
    beats_sent++;
  endtask

  // Write one register once every outstanding result is back. Keep cfg_valid high on return.
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEBOUNCE: cur_debounce = val;
      CFG_HOLD:     cur_hold     = val;
      CFG_MIN:      cur_min      = val[7:0];
      CFG_MAX:      cur_max      = val[7:0];
      CFG_STEP:     cur_step     = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Cycle limit: a hang ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check each accepted beat against the oldest expectation, then pick
  // the next ready value (forced low during a hold-off)
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding: tdata=%h", out_tdata);
        mismatch_count++;
      end else begin
        next_result = pending_results.pop_front();
        results_seen++;
        if (out_tdata[9])  button_changes++;
        if (out_tdata[10]) level_reports++;
        if (out_tdata[7:0] !== next_result.pwm) begin
          $error("pwm_level: expected %0d, actual %0d", next_result.pwm, out_tdata[7:0]);
          mismatch_count++;
        end
        if (out_tdata[8] !== next_result.pressed) begin
          $error("pressed: expected %0b, actual %0b", next_result.pressed, out_tdata[8]);
          mismatch_count++;
        end
        if (out_tdata[9] !== next_result.set_rep) begin
          $error("set_report: expected %0b, actual %0b", next_result.set_rep, out_tdata[9]);
          mismatch_count++;
        end
        if (out_tdata[10] !== next_result.get_rep) begin
          $error("get_report: expected %0b, actual %0b", next_result.get_rep, out_tdata[10]);
          mismatch_count++;
        end
      end
    end
    if (hold_off_left > 0) begin
      out_tready <= 1'b0;
      hold_off_left--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    int          ph;
    int          kind;
    int          len;
    int          d;
    int          h;
    logic [15:0] deb;
    logic [15:0] hold;
    logic [15:0] step;
    logic [7:0]  lo;
    logic [7:0]  hi;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling
    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].is_cfg) write_reg(DIRECTED[r].idx, DIRECTED[r].val);
      else send_tick(DIRECTED[r].tick, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // Random phases: fixed extremes first, then random settings
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          deb = 16'd0;     hold = 16'd0;     lo = 8'd0;   hi = 8'd255; step = 16'hFFFF;
        end
        1: begin
          deb = 16'hFFFF;  hold = 16'hFFFF;  lo = 8'd255; hi = 8'd255; step = 16'hFFFF;
        end
        2: begin
          deb = 16'd2;     hold = 16'd6;     lo = 8'd0;   hi = 8'd1;   step = 16'd1;
        end
        3: begin
          deb = 16'd1;     hold = 16'd4;     lo = 8'd40;  hi = 8'd200; step = 16'd0;
        end
        default: begin
          deb  = 16'($urandom_range(0, 4));
          hold = 16'($urandom_range(0, 12));
          hi   = 8'($urandom_range(1, 255));
          lo   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(hi, 255))
                                             : 8'($urandom_range(0, hi));
          step = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 255))
                                             : 16'($urandom_range(16'h0400, 16'h4000));
        end
      endcase
      write_reg(CFG_DEBOUNCE, deb);
      write_reg(CFG_HOLD, hold);
      write_reg(CFG_MIN, {8'd0, lo});
      write_reg(CFG_MAX, {8'd0, hi});
      write_reg(CFG_STEP, step);

      send_idle_pct  = SEND_IDLE_PCT[ph % 4];
      recv_stall_pct = RECV_STALL_PCT[ph % 4];

      // Build press episodes: bounce, held level, bounce, settled release.
      // Cap the lengths so that huge debounce or hold settings stay cheap.
      tick_plan.delete();
      d = (cur_debounce > 16) ? 16 : int'(cur_debounce);
      h = (cur_hold > 40) ? 40 : int'(cur_hold);
      while (tick_plan.size() < TICKS_PER_PHASE) begin
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
          repeat ($urandom_range(1, 12)) plan_tick(1'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(0, 3)) plan_tick(1'($urandom_range(0, 1)));
          len = (kind < 5) ? $urandom_range(1, d + h + 3) : d + h + $urandom_range(3, 40);
          repeat (len) plan_tick(1'b1);
          repeat ($urandom_range(0, 3)) plan_tick(1'($urandom_range(0, 1)));
          repeat (d + $urandom_range(2, 6)) plan_tick(1'b0);
        end
      end

      // Stall the result side long enough for the block to back up into its input
      if (ph == PRESSURE_PHASE) hold_off_left = HOLD_OFF_CYCLES;

      foreach (tick_plan[i]) begin
        if (ph == PAUSE_PHASE && i == TICKS_PER_PHASE / 2) begin
          in_tvalid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        send_tick(tick_plan[i], 1'b0, '0);
      end
    end

    // Drop valid, let everything drain, then watch a few more cycles for stray beats
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks over %0d register writes; checked %0d results.",
             beats_sent, reg_writes, results_seen);
    $display("Saw %0d button-driven level changes and %0d level reports; %0d mismatches.",
             button_changes, level_reports, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
